FILE: hdl/wbwc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Word break way counter package
// Shared constants, controller/datapath interface types and the saturating
// adder used for all way counts.
// ----------------------------------------------------------------------------
package wbwc_pkg;

  localparam int WORDS_DEFAULT    = 512;
  localparam int WORD_LEN_DEFAULT = 8;
  localparam int CHAR_W           = 8;
  localparam int COUNT_W          = 64;

  localparam logic REQ_WORD   = 1'b0;
  localparam logic REQ_DESIGN = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DUP_SCAN,
    ST_WRITE,
    ST_DES_SCAN,
    ST_DES_END
  } state_t;

  typedef struct packed {
    logic load_item;
    logic commit_check;
    logic scan_start;
    logic scan_design;
    logic scan_run;
    logic word_write;
    logic design_step;
    logic design_end;
  } cmd_t;

  typedef struct packed {
    logic commit_bad;
    logic scan_done;
    logic out_free;
  } sts_t;

  function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                 input logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: hdl/wbwc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Word break way counter controller
// Sequences request intake, dictionary commits, table scans and the end of
// each design position.
// ----------------------------------------------------------------------------
module wbwc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           in_req_type,
  input  wire logic           in_last,
  input  wire logic           last_r,
  input  wbwc_pkg::sts_t      sts,
  output wbwc_pkg::cmd_t      cmd
);

  wbwc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wbwc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wbwc_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_req_type == wbwc_pkg::REQ_DESIGN) begin
            state_nxt = wbwc_pkg::ST_DES_SCAN;
          end else if (in_last) begin
            state_nxt = wbwc_pkg::ST_CHECK;
          end
        end
      end
      wbwc_pkg::ST_CHECK: begin
        state_nxt = sts.commit_bad ? wbwc_pkg::ST_IDLE : wbwc_pkg::ST_DUP_SCAN;
      end
      wbwc_pkg::ST_DUP_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = wbwc_pkg::ST_WRITE;
        end
      end
      wbwc_pkg::ST_WRITE: begin
        state_nxt = wbwc_pkg::ST_IDLE;
      end
      wbwc_pkg::ST_DES_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = wbwc_pkg::ST_DES_END;
        end
      end
      wbwc_pkg::ST_DES_END: begin
        if (!last_r || sts.out_free) begin
          state_nxt = wbwc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wbwc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      wbwc_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
        if (in_valid && in_req_type == wbwc_pkg::REQ_DESIGN) begin
          cmd.scan_start  = 1'b1;
          cmd.scan_design = 1'b1;
        end
      end
      wbwc_pkg::ST_CHECK: begin
        cmd.commit_check = 1'b1;
        cmd.scan_start   = !sts.commit_bad;
      end
      wbwc_pkg::ST_DUP_SCAN: begin
        cmd.scan_run = 1'b1;
      end
      wbwc_pkg::ST_WRITE: begin
        cmd.word_write = 1'b1;
      end
      wbwc_pkg::ST_DES_SCAN: begin
        cmd.scan_run = 1'b1;
      end
      wbwc_pkg::ST_DES_END: begin
        cmd.design_step = !last_r;
        cmd.design_end  = last_r && sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/wbwc_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Word break way counter datapath
// Word memory, pending word buffer, recent character and count windows,
// two-stage scan pipeline and the result register.
// ----------------------------------------------------------------------------
module wbwc_dpath #(
  parameter int MAX_WORDS    = wbwc_pkg::WORDS_DEFAULT,
  parameter int MAX_WORD_LEN = wbwc_pkg::WORD_LEN_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wbwc_pkg::cmd_t                    cmd,
  output wbwc_pkg::sts_t                    sts,
  output logic                              last_r,
  input  wire logic                         in_req_type,
  input  wire logic [wbwc_pkg::CHAR_W-1:0]  in_char_value,
  input  wire logic                         in_last,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [wbwc_pkg::COUNT_W-1:0]      out_ways,
  output logic [wbwc_pkg::COUNT_W-1:0]      out_total,
  output logic                              out_overflow
);

  localparam int L   = MAX_WORD_LEN;
  localparam int CHW = wbwc_pkg::CHAR_W;
  localparam int NW  = wbwc_pkg::COUNT_W;
  localparam int LW  = $clog2(L + 1);
  localparam int PW  = $clog2(L + 2);
  localparam int IW  = (L > 1) ? $clog2(L) : 1;
  localparam int CW  = $clog2(MAX_WORDS + 1);
  localparam int AW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int WB  = L * CHW;
  localparam int EW  = WB + LW;

  logic [EW-1:0]  mem [MAX_WORDS];

  logic [CHW-1:0] pend_r   [L];
  logic [CHW-1:0] recent_r [L];
  logic [NW-1:0]  win_r    [L];
  logic [PW-1:0]  load_pos_r;
  logic [CW-1:0]  word_count_r;
  logic [LW-1:0]  dpos_r;
  logic [NW-1:0]  total_r;
  logic           ovf_r;
  logic           scan_design_r;
  logic [CW-1:0]  scan_cnt_r;
  logic           rd_v_r;
  logic           term_v_r;
  logic [EW-1:0]  rd_q_r;
  logic           match_r;
  logic [NW-1:0]  term_r;
  logic [NW-1:0]  sum_r;
  logic           dup_r;
  logic [WB-1:0]  wr_word_r;
  logic [LW-1:0]  wr_len_r;
  logic           out_valid_r;
  logic [NW-1:0]  out_ways_r;
  logic [NW-1:0]  out_total_r;
  logic           out_ovf_r;

  logic           rd_issue;
  logic [WB-1:0]  pend_rev;
  logic [LW-1:0]  ent_len;
  logic [WB-1:0]  ent_word;
  logic           des_match;
  logic           dup_match;
  logic [NW-1:0]  new_total;

  assign rd_issue  = cmd.scan_run && (scan_cnt_r < word_count_r);
  assign ent_len   = rd_q_r[EW-1 -: LW];
  assign ent_word  = rd_q_r[WB-1:0];
  assign new_total = wbwc_pkg::sat_add(total_r, sum_r);

  assign sts.commit_bad = (load_pos_r > PW'(L)) || (word_count_r >= CW'(MAX_WORDS));
  assign sts.scan_done  = (scan_cnt_r == word_count_r) && !rd_v_r && !term_v_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign out_ways     = out_ways_r;
  assign out_total    = out_total_r;
  assign out_overflow = out_ovf_r;

  // Words are stored last character first so that entry byte k lines up
  // with the k-th most recent design character.
  always_comb begin
    int idx;
    pend_rev = '0;
    for (int k = 0; k < L; k++) begin
      idx = int'(load_pos_r) - 1 - k;
      if (k < int'(load_pos_r)) begin
        pend_rev[k*CHW +: CHW] = pend_r[IW'(idx)];
      end
    end
  end

  always_comb begin
    des_match = (ent_len != '0) && (ent_len <= dpos_r);
    dup_match = (ent_len == wr_len_r);
    for (int k = 0; k < L; k++) begin
      if (k < int'(ent_len)) begin
        if (ent_word[k*CHW +: CHW] != recent_r[k]) begin
          des_match = 1'b0;
        end
        if (ent_word[k*CHW +: CHW] != wr_word_r[k*CHW +: CHW]) begin
          dup_match = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.word_write && !dup_r) begin
      mem[word_count_r[AW-1:0]] <= {wr_len_r, wr_word_r};
    end
    if (rd_issue) begin
      rd_q_r <= mem[scan_cnt_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item && in_req_type == wbwc_pkg::REQ_WORD && load_pos_r < PW'(L)) begin
      pend_r[load_pos_r[IW-1:0]] <= in_char_value;
    end
    if (cmd.commit_check) begin
      wr_word_r <= pend_rev;
      wr_len_r  <= load_pos_r[LW-1:0];
    end
    if (rd_v_r) begin
      match_r <= scan_design_r ? des_match : dup_match;
      term_r  <= win_r[IW'(ent_len - LW'(1))];
    end
    if (cmd.design_end) begin
      out_ways_r  <= sum_r;
      out_total_r <= new_total;
      out_ovf_r   <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_pos_r    <= '0;
      word_count_r  <= '0;
      dpos_r        <= '0;
      total_r       <= '0;
      ovf_r         <= 1'b0;
      last_r        <= 1'b0;
      scan_design_r <= 1'b0;
      scan_cnt_r    <= '0;
      rd_v_r        <= 1'b0;
      term_v_r      <= 1'b0;
      sum_r         <= '0;
      dup_r         <= 1'b0;
      out_valid_r   <= 1'b0;
      for (int k = 0; k < L; k++) begin
        recent_r[k] <= '0;
        win_r[k]    <= (k == 0) ? NW'(1) : '0;
      end
    end else begin
      if (cmd.load_item) begin
        last_r <= in_last;
        if (in_req_type == wbwc_pkg::REQ_WORD) begin
          if (load_pos_r <= PW'(L)) begin
            load_pos_r <= load_pos_r + PW'(1);
          end
        end else begin
          recent_r[0] <= in_char_value;
          for (int k = 1; k < L; k++) begin
            recent_r[k] <= recent_r[k-1];
          end
          if (dpos_r < LW'(L)) begin
            dpos_r <= dpos_r + LW'(1);
          end
        end
      end
      if (cmd.commit_check) begin
        load_pos_r <= '0;
        if (sts.commit_bad) begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.scan_start) begin
        scan_design_r <= cmd.scan_design;
        scan_cnt_r    <= '0;
        sum_r         <= '0;
        dup_r         <= 1'b0;
      end else if (rd_issue) begin
        scan_cnt_r <= scan_cnt_r + CW'(1);
      end
      rd_v_r   <= rd_issue;
      term_v_r <= rd_v_r;
      if (term_v_r && match_r) begin
        if (scan_design_r) begin
          sum_r <= wbwc_pkg::sat_add(sum_r, term_r);
        end else begin
          dup_r <= 1'b1;
        end
      end
      if (cmd.word_write && !dup_r) begin
        word_count_r <= word_count_r + CW'(1);
      end
      if (cmd.design_step) begin
        win_r[0] <= sum_r;
        for (int k = 1; k < L; k++) begin
          win_r[k] <= win_r[k-1];
        end
      end
      if (cmd.design_end) begin
        total_r     <= new_total;
        dpos_r      <= '0;
        out_valid_r <= 1'b1;
        for (int k = 0; k < L; k++) begin
          recent_r[k] <= '0;
          win_r[k]    <= (k == 0) ? NW'(1) : '0;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/word_break_way_counter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Word break way counter core
// Counts the ways each streamed design splits into stored dictionary words.
//
//   Channel  Handshake             Fields
//   in_      in_valid/in_ready     in_req_type, in_char_value, in_last
//   out_     out_valid/out_ready   out_ways, out_total, out_overflow
//
// A word character that is not last is taken without leaving idle. A final
// word character starts a duplicate scan of the table (none if it is dropped)
// and a design character starts a table scan, and the core is busy until it
// ends, as the single word memory read port scans one entry a cycle.
// Reset needs no clearing pass: only entries below the word count are read.
// A finished design waits in its final step while an earlier result is held.
// ----------------------------------------------------------------------------
module word_break_way_counter_core #(
  parameter int MAX_WORDS    = wbwc_pkg::WORDS_DEFAULT,
  parameter int MAX_WORD_LEN = wbwc_pkg::WORD_LEN_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_req_type,
  input  wire logic [wbwc_pkg::CHAR_W-1:0]  in_char_value,
  input  wire logic                         in_last,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [wbwc_pkg::COUNT_W-1:0]      out_ways,
  output logic [wbwc_pkg::COUNT_W-1:0]      out_total,
  output logic                              out_overflow
);

  wbwc_pkg::cmd_t cmd;
  wbwc_pkg::sts_t sts;
  logic           last_r;

  wbwc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_last     (in_last),
    .last_r      (last_r),
    .sts         (sts),
    .cmd         (cmd)
  );

  wbwc_dpath #(
    .MAX_WORDS    (MAX_WORDS),
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .last_r        (last_r),
    .in_req_type   (in_req_type),
    .in_char_value (in_char_value),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_ways      (out_ways),
    .out_total     (out_total),
    .out_overflow  (out_overflow)
  );

endmodule
`default_nettype wire

FILE: hdl/wbwc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Word break way counter checker
// Port-level assertions on reset, held results, totals, the sticky overflow
// flag and design intake.
module wbwc_props (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         in_req_type,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [wbwc_pkg::COUNT_W-1:0] out_ways,
  input wire logic [wbwc_pkg::COUNT_W-1:0] out_total,
  input wire logic                         out_overflow
);

  logic [wbwc_pkg::COUNT_W-1:0] last_total_r;
  logic                         seen_ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_total_r <= '0;
      seen_ovf_r   <= 1'b0;
    end else if (out_valid && out_ready) begin
      last_total_r <= out_total;
      seen_ovf_r   <= seen_ovf_r || out_overflow;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ways) && $stable(out_total))
    else $error("stalled result changed");

  a_total_covers_ways: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_total >= out_ways && out_total >= last_total_r)
    else $error("running total below this design or an earlier total");

  a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_ovf_r |-> out_overflow)
    else $error("overflow flag cleared");

  a_design_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == wbwc_pkg::REQ_DESIGN |=> !in_ready)
    else $error("design character taken without a table scan");

endmodule

bind word_break_way_counter_core wbwc_props u_wbwc_props (.*);
`default_nettype wire

FILE: test/wbwc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Word break way counter checker
// Watches both channels of the core, keeps its own copy of the dictionary and
// the prefix counts of the current design, and predicts the ways and running
// total of every finished design. Results are compared field by field, in
// order, against the oldest prediction.
// ----------------------------------------------------------------------------
module wbwc_checker (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic                         in_ready,
  input  wire logic                         in_req_type,
  input  wire logic [wbwc_pkg::CHAR_W-1:0]  in_char_value,
  input  wire logic                         in_last,
  input  wire logic                         out_valid,
  input  wire logic                         out_ready,
  input  wire logic [wbwc_pkg::COUNT_W-1:0] out_ways,
  input  wire logic [wbwc_pkg::COUNT_W-1:0] out_total,
  input  wire logic                         out_overflow,
  output int                                fail_count,
  output int                                awaiting
);

  localparam int DICT_DEPTH = wbwc_pkg::WORDS_DEFAULT;
  localparam int SPAN       = wbwc_pkg::WORD_LEN_DEFAULT;

  typedef struct packed {
    logic [wbwc_pkg::COUNT_W-1:0] ways;
    logic [wbwc_pkg::COUNT_W-1:0] total;
    logic                         overflow;
  } split_report_t;

  logic [wbwc_pkg::CHAR_W-1:0]  dict_chars [DICT_DEPTH][SPAN];
  int                           dict_len   [DICT_DEPTH];
  int                           dict_size;
  int                           load_pos;
  int                           design_pos;
  logic [wbwc_pkg::CHAR_W-1:0]  word_buf    [SPAN];
  logic [wbwc_pkg::CHAR_W-1:0]  tail        [SPAN];
  logic [wbwc_pkg::COUNT_W-1:0] prefix_ways [SPAN];
  logic [wbwc_pkg::COUNT_W-1:0] total_ways;
  logic                         sticky_ovf;
  split_report_t                report_q[$];
  int                           mismatches = 0;

  assign fail_count = mismatches;

  function automatic logic [wbwc_pkg::COUNT_W-1:0] add_capped(
      input logic [wbwc_pkg::COUNT_W-1:0] a,
      input logic [wbwc_pkg::COUNT_W-1:0] b);
    logic [wbwc_pkg::COUNT_W-1:0] s;
    s = a + b;
    return (s < a) ? '1 : s;
  endfunction

  task automatic restart_design();
    int k;
    for (k = 0; k < SPAN; k++) begin
      tail[k]        = '0;
      prefix_ways[k] = '0;
    end
    prefix_ways[0] = wbwc_pkg::COUNT_W'(1);
    design_pos     = 0;
  endtask

  task automatic clear_model();
    dict_size  = 0;
    load_pos   = 0;
    total_ways = '0;
    sticky_ovf = 1'b0;
    restart_design();
    report_q.delete();
  endtask

  task automatic store_word();
    int  n;
    int  w;
    int  k;
    bit  same;
    n        = load_pos;
    load_pos = 0;
    if (n > SPAN || dict_size >= DICT_DEPTH) begin
      sticky_ovf = 1'b1;
      return;
    end
    for (w = 0; w < dict_size; w++) begin
      if (dict_len[w] == n) begin
        same = 1'b1;
        for (k = 0; k < n; k++) begin
          if (dict_chars[w][k] != word_buf[k]) same = 1'b0;
        end
        if (same) return;
      end
    end
    for (k = 0; k < n; k++) dict_chars[dict_size][k] = word_buf[k];
    dict_len[dict_size] = n;
    dict_size++;
  endtask

  task automatic take_design_char(input logic [wbwc_pkg::CHAR_W-1:0] c, input logic fin);
    logic [wbwc_pkg::COUNT_W-1:0] sum;
    int                           n;
    int                           w;
    int                           k;
    bit                           hit;
    split_report_t                rec;
    for (k = SPAN - 1; k > 0; k--) tail[k] = tail[k-1];
    tail[0] = c;
    if (design_pos < SPAN) design_pos++;
    sum = '0;
    for (w = 0; w < dict_size; w++) begin
      n   = dict_len[w];
      hit = (n >= 1) && (n <= design_pos);
      for (k = 0; hit && k < n; k++) begin
        if (dict_chars[w][n-1-k] != tail[k]) hit = 1'b0;
      end
      if (hit) sum = add_capped(sum, prefix_ways[n-1]);
    end
    for (k = SPAN - 1; k > 0; k--) prefix_ways[k] = prefix_ways[k-1];
    prefix_ways[0] = sum;
    if (fin) begin
      total_ways   = add_capped(total_ways, sum);
      rec.ways     = sum;
      rec.total    = total_ways;
      rec.overflow = sticky_ovf;
      report_q.insert(report_q.size(), rec);
      restart_design();
    end
  endtask

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    split_report_t want;
    if (!rst_n) begin
      clear_model();
    end else begin
      if (in_valid && in_ready) begin
        if (in_req_type == wbwc_pkg::REQ_WORD) begin
          if (load_pos < SPAN) word_buf[load_pos] = in_char_value;
          if (load_pos <= SPAN) load_pos++;
          if (in_last) store_word();
        end else begin
          take_design_char(in_char_value, in_last);
        end
      end
      if (out_valid && out_ready) begin
        if (report_q.size() == 0) begin
          flag_mismatch($sformatf("result with no request pending, ways %0d total %0d",
                                  out_ways, out_total));
        end else begin
          want = report_q.pop_front();
          if (out_ways !== want.ways)
            flag_mismatch($sformatf("ways %0d, predicted %0d", out_ways, want.ways));
          if (out_total !== want.total)
            flag_mismatch($sformatf("total %0d, predicted %0d", out_total, want.total));
          if (out_overflow !== want.overflow)
            flag_mismatch($sformatf("overflow %0b, predicted %0b",
                                    out_overflow, want.overflow));
        end
      end
    end
    awaiting <= report_q.size();
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Word break way counter testbench
// Drives dictionary and design requests into the core with random gaps and
// back-pressure: a short directed opening, a random mix of words and designs
// and finally saturating runs of one repeated character. The checker beside
// the core predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;

  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 600;
  localparam int RANDOM_ITEMS = 330;
  localparam int IDLE_PCT     = 11;
  localparam int WORD_CAP     = 60;
  localparam int SAT_LEN      = 80;

  logic                         clk           = 1'b0;
  logic                         rst_n         = 1'b0;
  logic                         in_valid      = 1'b0;
  logic                         in_req_type   = wbwc_pkg::REQ_WORD;
  logic [wbwc_pkg::CHAR_W-1:0]  in_char_value = '0;
  logic                         in_last       = 1'b0;
  logic                         out_ready     = 1'b0;
  logic                         in_ready;
  logic                         out_valid;
  logic [wbwc_pkg::COUNT_W-1:0] out_ways;
  logic [wbwc_pkg::COUNT_W-1:0] out_total;
  logic                         out_overflow;
  int                           fail_count;
  int                           awaiting;

  bit calm          = 1'b0;
  int items_sent    = 0;
  int words_loaded  = 0;
  int stall_cycles  = 0;

  always #5 clk = ~clk;

  word_break_way_counter_core u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_char_value (in_char_value),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_ways      (out_ways),
    .out_total     (out_total),
    .out_overflow  (out_overflow)
  );

  wbwc_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_char_value (in_char_value),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_ways      (out_ways),
    .out_total     (out_total),
    .out_overflow  (out_overflow),
    .fail_count    (fail_count),
    .awaiting      (awaiting)
  );

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("word_break_way_counter_core verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_request(input logic kind, input logic [wbwc_pkg::CHAR_W-1:0] ch,
                              input logic fin);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= kind;
    in_char_value <= ch;
    in_last       <= fin;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_word(input logic [63:0] w, input int n);
    int i;
    for (i = 0; i < n; i++) begin
      send_request(wbwc_pkg::REQ_WORD, w[8*(n-1-i) +: 8], i == n - 1);
    end
    words_loaded++;
  endtask

  task automatic send_design(input logic [63:0] s, input int n);
    int i;
    for (i = 0; i < n; i++) begin
      send_request(wbwc_pkg::REQ_DESIGN, s[8*(n-1-i) +: 8], i == n - 1);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  function automatic logic [wbwc_pkg::CHAR_W-1:0] pick_char();
    if ($urandom_range(0, 9) == 0) return wbwc_pkg::CHAR_W'($urandom);
    return 8'h61 + wbwc_pkg::CHAR_W'($urandom_range(0, 2));
  endfunction

  task automatic random_word();
    int n;
    int r;
    int i;
    r = $urandom_range(0, 19);
    if (r == 0) n = $urandom_range(9, 11);
    else if (r == 1) n = 8;
    else n = $urandom_range(1, 4);
    for (i = 0; i < n; i++) send_request(wbwc_pkg::REQ_WORD, pick_char(), i == n - 1);
    words_loaded++;
  endtask

  initial begin
    int          start;
    int          n;
    int          i;
    int          j;
    bit          paused;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: empty dictionary, character extremes, a duplicate,
    // an over-long word and a word loaded in the middle of a design.
    send_design(64'h00, 1);
    send_word(64'h00, 1);
    send_word(64'hFF, 1);
    send_word(64'h00FF, 2);
    send_word(64'h00, 1);
    send_design(64'h00FF00FF, 4);
    for (i = 0; i < 9; i++) send_request(wbwc_pkg::REQ_WORD, 8'h78, i == 8);
    words_loaded++;
    send_request(wbwc_pkg::REQ_DESIGN, 8'h00, 1'b0);
    send_word(64'h0000, 2);
    send_request(wbwc_pkg::REQ_DESIGN, 8'h00, 1'b1);

    start  = items_sent;
    paused = 1'b0;
    while (items_sent < start + RANDOM_ITEMS) begin
      calm <= (items_sent - start >= 100) && (items_sent - start < 180);
      if (!paused && items_sent - start >= 250) begin
        drain_results();
        paused = 1'b1;
      end
      if (words_loaded < WORD_CAP && $urandom_range(0, 3) == 0) begin
        random_word();
      end else begin
        n = $urandom_range(1, 12);
        for (i = 0; i < n; i++) begin
          if (words_loaded < WORD_CAP && $urandom_range(0, 29) == 0) random_word();
          send_request(wbwc_pkg::REQ_DESIGN, pick_char(), i == n - 1);
        end
      end
    end
    calm <= 1'b0;

    // Runs of one character over words of every length saturate the counts.
    for (n = 1; n <= wbwc_pkg::WORD_LEN_DEFAULT; n++) send_word({8{8'h5A}}, n);
    for (j = 0; j < 2; j++) begin
      for (i = 0; i < SAT_LEN; i++) begin
        send_request(wbwc_pkg::REQ_DESIGN, 8'h5A, i == SAT_LEN - 1);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("word_break_way_counter_core verification clean");
    end else begin
      $display("word_break_way_counter_core verification failed");
    end
    $finish;
  end

endmodule
